// ===== src/dhqp_pkg.sv =====
// ============================================================================
// dhqp_pkg
// Shared types and constants for the DNS header and question name parser.
// ============================================================================
package dhqp_pkg;

    localparam logic [3:0] HDR_BYTES   = 4'd12;
    localparam logic [3:0] HDR_LAST    = 4'd11;
    localparam int         HDR_WORDS   = 6;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] NUL_CHAR    = 8'h00;
    localparam logic       KIND_CHAR   = 1'b0;
    localparam logic       KIND_SUM    = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_LABEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic [15:0] transaction_id;
        logic [15:0] header_flags;
        logic [15:0] query_count;
        logic [15:0] answer_count;
        logic [15:0] authority_count;
        logic [15:0] additional_count;
        logic [7:0]  name_length;
        logic        status;
    } res_t;

    typedef struct packed {
        logic char_valid;
        logic sum_valid;
        res_t char_res;
        res_t sum_res;
    } res_pair_t;

endpackage

// ===== src/dhqp_parser.sv =====
// ============================================================================
// dhqp_parser
// Header capture and label decoder: updates the message state for one byte
// and forms the character and summary results that byte causes.
// ============================================================================
module dhqp_parser #(
    parameter int MAX_NAME = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                over_tcp,
    input  logic                last_byte,
    output dhqp_pkg::res_pair_t results
);

    localparam int NW = $clog2(MAX_NAME) + 1;
    localparam int SW = NW + 9;
    localparam logic [SW-1:0] NAME_LIMIT = SW'(MAX_NAME - 1);

    logic [3:0]            pos_reg, pos_next;
    logic [15:0]           hdr_reg [dhqp_pkg::HDR_WORDS];
    logic [15:0]           hdr_next [dhqp_pkg::HDR_WORDS];
    dhqp_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]            label_rem_reg, label_rem_next;
    logic [NW-1:0]         name_count_reg, name_count_next;
    logic                  first_label_reg, first_label_next;

    logic                  in_header;
    logic [2:0]            word_idx;
    logic [SW-1:0]         run_len;
    logic                  name_stop;

    assign in_header = (pos_reg < dhqp_pkg::HDR_BYTES);
    assign word_idx  = pos_reg[3:1];
    assign run_len   = SW'(name_count_reg) + SW'(!first_label_reg) + SW'(data_byte);
    assign name_stop = (data_byte == dhqp_pkg::NUL_CHAR) || (run_len >= NAME_LIMIT);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_header) begin
            if (pos_reg == dhqp_pkg::HDR_LAST) begin
                phase_next = (!over_tcp && (hdr_reg[2] != 16'd0)) ?
                             dhqp_pkg::PH_LENGTH : dhqp_pkg::PH_DONE;
            end
        end else begin
            unique case (phase_reg)
                dhqp_pkg::PH_HEADER: phase_next = dhqp_pkg::PH_HEADER;
                dhqp_pkg::PH_LENGTH: begin
                    phase_next = name_stop ? dhqp_pkg::PH_DONE : dhqp_pkg::PH_LABEL;
                end
                dhqp_pkg::PH_LABEL: begin
                    phase_next = (label_rem_reg == 8'd1) ?
                                 dhqp_pkg::PH_LENGTH : dhqp_pkg::PH_LABEL;
                end
                dhqp_pkg::PH_DONE:   phase_next = dhqp_pkg::PH_DONE;
                default:             phase_next = dhqp_pkg::PH_DONE;
            endcase
        end
    end

    // datapath and results
    always_comb begin
        hdr_next         = hdr_reg;
        label_rem_next   = label_rem_reg;
        name_count_next  = name_count_reg;
        first_label_next = first_label_reg;
        pos_next         = (pos_reg == dhqp_pkg::HDR_BYTES) ? pos_reg : pos_reg + 4'd1;
        results          = '0;

        if (in_header) begin
            if (!pos_reg[0]) begin
                hdr_next[word_idx][15:8] = data_byte;
            end else begin
                hdr_next[word_idx][7:0] = data_byte;
            end
        end else if (phase_reg == dhqp_pkg::PH_LENGTH) begin
            if (!name_stop) begin
                if (!first_label_reg) begin
                    results.char_valid          = 1'b1;
                    results.char_res.name_char  = dhqp_pkg::DOT_CHAR;
                    name_count_next             = name_count_reg + NW'(1);
                end
                first_label_next = 1'b0;
                label_rem_next   = data_byte;
            end
        end else if (phase_reg == dhqp_pkg::PH_LABEL) begin
            results.char_valid         = 1'b1;
            results.char_res.name_char = data_byte;
            name_count_next            = name_count_reg + NW'(1);
            label_rem_next             = label_rem_reg - 8'd1;
        end

        results.char_res.kind = dhqp_pkg::KIND_CHAR;

        results.sum_valid                 = last_byte;
        results.sum_res.kind              = dhqp_pkg::KIND_SUM;
        results.sum_res.name_char         = dhqp_pkg::NUL_CHAR;
        results.sum_res.transaction_id    = hdr_next[0];
        results.sum_res.header_flags      = hdr_next[1];
        results.sum_res.query_count       = hdr_next[2];
        results.sum_res.answer_count      = hdr_next[3];
        results.sum_res.authority_count   = hdr_next[4];
        results.sum_res.additional_count  = hdr_next[5];
        results.sum_res.name_length       = 8'(name_count_next);
        results.sum_res.status            = (pos_reg < dhqp_pkg::HDR_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last_byte)) begin
            pos_reg         <= '0;
            phase_reg       <= dhqp_pkg::PH_HEADER;
            label_rem_reg   <= '0;
            name_count_reg  <= '0;
            first_label_reg <= 1'b1;
            for (int i = 0; i < dhqp_pkg::HDR_WORDS; i++) begin
                hdr_reg[i] <= '0;
            end
        end else if (advance) begin
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            label_rem_reg   <= label_rem_next;
            name_count_reg  <= name_count_next;
            first_label_reg <= first_label_next;
            hdr_reg         <= hdr_next;
        end
    end

endmodule

// ===== src/dhqp_out_fifo.sv =====
// ============================================================================
// dhqp_out_fifo
// Four-entry result queue: takes up to two results per cycle, hands out one
// per transfer.
// ============================================================================
module dhqp_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dhqp_pkg::res_pair_t push_data,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output dhqp_pkg::res_t      out_data
);

    dhqp_pkg::res_t  mem [4];
    logic [1:0]      wr_ptr_reg, wr_ptr_next;
    logic [1:0]      rd_ptr_reg, rd_ptr_next;
    logic [2:0]      count_reg, count_next;
    logic [1:0]      n_push;
    logic            pop;
    dhqp_pkg::res_t  first_res;

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = push ? (2'(push_data.char_valid) + 2'(push_data.sum_valid)) : 2'd0;
    assign first_res = push_data.char_valid ? push_data.char_res : push_data.sum_res;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(n_push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_ptr_reg] <= first_res;
        end
        if (n_push == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push_data.sum_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/dns_header_and_qname_parser_core.sv =====
// ============================================================================
// dns_header_and_qname_parser_core
// DNS message header and first question name parser, one byte per transfer.
// ============================================================================
// Feed the DNS message one byte per transfer, marking the final byte with
// s_last_byte. Each byte is taken from the input register when the queue
// has room, so one byte per clock is sustained; results leave through a
// four-entry queue, and a byte that yields both a name character and the
// summary occupies two queue slots, so input stalls only when m_ready holds
// the queue near full. Name characters come out with m_kind low; the summary
// with the header words, name length and short-header status always comes
// last for each message, after which the parser is clear for the next one.
module dns_header_and_qname_parser_core #(
    parameter int MAX_NAME = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_over_tcp,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_name_char,
    output logic [15:0] m_transaction_id,
    output logic [15:0] m_header_flags,
    output logic [15:0] m_query_count,
    output logic [15:0] m_answer_count,
    output logic [15:0] m_authority_count,
    output logic [15:0] m_additional_count,
    output logic [7:0]  m_name_length,
    output logic        m_status
);

    logic                in_valid_reg;
    logic [7:0]          data_reg;
    logic                tcp_reg;
    logic                last_reg;
    logic                advance;
    logic                room;
    dhqp_pkg::res_pair_t results;
    dhqp_pkg::res_t      out_data;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data_byte;
            tcp_reg  <= s_over_tcp;
            last_reg <= s_last_byte;
        end
    end

    dhqp_parser #(
        .MAX_NAME (MAX_NAME)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (data_reg),
        .over_tcp  (tcp_reg),
        .last_byte (last_reg),
        .results   (results)
    );

    dhqp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_data (results),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_kind             = out_data.kind;
    assign m_name_char        = out_data.name_char;
    assign m_transaction_id   = out_data.transaction_id;
    assign m_header_flags     = out_data.header_flags;
    assign m_query_count      = out_data.query_count;
    assign m_answer_count     = out_data.answer_count;
    assign m_authority_count  = out_data.authority_count;
    assign m_additional_count = out_data.additional_count;
    assign m_name_length      = out_data.name_length;
    assign m_status           = out_data.status;

endmodule

// ===== bench/dhqp_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dhqp_checker
// Watches both channels of the DNS header and name parser, decodes each
// accepted byte on its own copy of the parser state, and compares every
// result transfer field by field against the oldest predicted record.
// ============================================================================
module dhqp_checker #(
    parameter int NAME_LIMIT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_over_tcp,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_name_char,
    input  logic [15:0] m_transaction_id,
    input  logic [15:0] m_header_flags,
    input  logic [15:0] m_query_count,
    input  logic [15:0] m_answer_count,
    input  logic [15:0] m_authority_count,
    input  logic [15:0] m_additional_count,
    input  logic [7:0]  m_name_length,
    input  logic        m_status,
    output int          mismatches,
    output int          outstanding
);

    dhqp_pkg::res_t   dns_results_q[$];
    logic [15:0]      byte_pos;
    logic [15:0]      hdr_words[dhqp_pkg::HDR_WORDS];
    dhqp_pkg::phase_t name_state;
    logic [7:0]       label_left;
    int               name_cnt;
    logic             first_lbl;
    int               err_count;

    initial begin
        err_count   = 0;
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic clear_parser();
        byte_pos = '0;
        for (int i = 0; i < dhqp_pkg::HDR_WORDS; i++) hdr_words[i] = '0;
        name_state = dhqp_pkg::PH_HEADER;
        label_left = '0;
        name_cnt   = 0;
        first_lbl  = 1'b1;
    endtask

    function automatic dhqp_pkg::res_t char_record(input logic [7:0] ch);
        dhqp_pkg::res_t r;
        r = '0;
        r.kind      = dhqp_pkg::KIND_CHAR;
        r.name_char = ch;
        return r;
    endfunction

    task automatic decode_dns_byte(input logic [7:0] b, input logic tcp, input logic last);
        dhqp_pkg::res_t r;
        int             run;
        logic [15:0]    pos;
        pos = byte_pos;
        if (pos < dhqp_pkg::HDR_BYTES) begin
            if (pos[0] == 1'b0) hdr_words[pos[3:1]][15:8] = b;
            else hdr_words[pos[3:1]][7:0] = b;
            if (pos == dhqp_pkg::HDR_LAST)
                name_state = (!tcp && hdr_words[2] != 16'd0) ? dhqp_pkg::PH_LENGTH
                                                             : dhqp_pkg::PH_DONE;
        end else if (name_state == dhqp_pkg::PH_LENGTH) begin
            run = name_cnt + (first_lbl ? 0 : 1);
            if (b == dhqp_pkg::NUL_CHAR || run + int'(b) >= NAME_LIMIT - 1) begin
                name_state = dhqp_pkg::PH_DONE;
            end else begin
                if (!first_lbl) begin
                    dns_results_q.push_back(char_record(dhqp_pkg::DOT_CHAR));
                    name_cnt++;
                end
                first_lbl  = 1'b0;
                label_left = b;
                name_state = dhqp_pkg::PH_LABEL;
            end
        end else if (name_state == dhqp_pkg::PH_LABEL) begin
            dns_results_q.push_back(char_record(b));
            name_cnt++;
            if (label_left != 8'd0) label_left--;
            if (label_left == 8'd0) name_state = dhqp_pkg::PH_LENGTH;
        end
        if (byte_pos != 16'hFFFF) byte_pos++;
        if (last) begin
            r = '0;
            r.kind             = dhqp_pkg::KIND_SUM;
            r.transaction_id   = hdr_words[0];
            r.header_flags     = hdr_words[1];
            r.query_count      = hdr_words[2];
            r.answer_count     = hdr_words[3];
            r.authority_count  = hdr_words[4];
            r.additional_count = hdr_words[5];
            r.name_length      = name_cnt[7:0];
            r.status           = (int'(pos) + 1 < int'(dhqp_pkg::HDR_BYTES));
            dns_results_q.push_back(r);
            clear_parser();
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        dhqp_pkg::res_t want;
        if (!aresetn) begin
            clear_parser();
            dns_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (dns_results_q.size() == 0) begin
                    $error("result transfer with nothing expected: kind %0d char %0h",
                           m_kind, m_name_char);
                    err_count++;
                end else begin
                    want = dns_results_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_kind));
                    check_field("name_char", 16'(want.name_char), 16'(m_name_char));
                    check_field("transaction_id", want.transaction_id, m_transaction_id);
                    check_field("header_flags", want.header_flags, m_header_flags);
                    check_field("query_count", want.query_count, m_query_count);
                    check_field("answer_count", want.answer_count, m_answer_count);
                    check_field("authority_count", want.authority_count, m_authority_count);
                    check_field("additional_count", want.additional_count,
                                m_additional_count);
                    check_field("name_length", 16'(want.name_length), 16'(m_name_length));
                    check_field("status", 16'(want.status), 16'(m_status));
                end
            end
            if (s_valid && s_ready) decode_dns_byte(s_data_byte, s_over_tcp, s_last_byte);
        end
        mismatches  <= err_count;
        outstanding <= dns_results_q.size();
    end

endmodule

// ===== bench/tb_dns_header_and_qname_parser_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_dns_header_and_qname_parser_core
// Feeds DNS messages byte by byte into the parser: directed corner cases
// (short headers, TCP, empty question, names cut short, name length limit)
// followed by random well-formed and broken messages, with random idling
// on both channels. The checker does the rest.
// ============================================================================
module tb_dns_header_and_qname_parser_core;

    localparam int MAX_NAME = 256;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_over_tcp  = 1'b0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_kind;
    logic [7:0]  m_name_char;
    logic [15:0] m_transaction_id;
    logic [15:0] m_header_flags;
    logic [15:0] m_query_count;
    logic [15:0] m_answer_count;
    logic [15:0] m_authority_count;
    logic [15:0] m_additional_count;
    logic [7:0]  m_name_length;
    logic        m_status;

    int          mismatches;
    int          outstanding;
    bit          tx_steady  = 1'b0;
    bit          rx_steady  = 1'b0;
    int          rx_hold    = 0;
    int          sent_bytes = 0;
    logic [7:0]  msg_bytes[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dns_header_and_qname_parser_core #(
        .MAX_NAME(MAX_NAME)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_over_tcp         (s_over_tcp),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_name_char        (m_name_char),
        .m_transaction_id   (m_transaction_id),
        .m_header_flags     (m_header_flags),
        .m_query_count      (m_query_count),
        .m_answer_count     (m_answer_count),
        .m_authority_count  (m_authority_count),
        .m_additional_count (m_additional_count),
        .m_name_length      (m_name_length),
        .m_status           (m_status)
    );

    dhqp_checker #(
        .NAME_LIMIT(MAX_NAME)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_over_tcp         (s_over_tcp),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_name_char        (m_name_char),
        .m_transaction_id   (m_transaction_id),
        .m_header_flags     (m_header_flags),
        .m_query_count      (m_query_count),
        .m_answer_count     (m_answer_count),
        .m_authority_count  (m_authority_count),
        .m_additional_count (m_additional_count),
        .m_name_length      (m_name_length),
        .m_status           (m_status),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_steady || $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            rx_hold <= gap_len();
        end
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready) sent_bytes <= sent_bytes + 1;
    end

    task automatic send_byte(input logic [7:0] b, input logic tcp, input logic last);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_over_tcp  <= tcp;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // over_tcp only matters on header byte 11; randomize it everywhere else
    task automatic send_message(input logic tcp);
        int n;
        n = msg_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_bytes[i], (i == 11) ? tcp : 1'($urandom_range(0, 1)), i == n - 1);
        msg_bytes.delete();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic add_word(input logic [15:0] w);
        msg_bytes.push_back(w[15:8]);
        msg_bytes.push_back(w[7:0]);
    endtask

    task automatic add_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns, input logic [15:0] ar);
        add_word(id);
        add_word(flags);
        add_word(qd);
        add_word(an);
        add_word(ns);
        add_word(ar);
    endtask

    task automatic add_random_header(input logic [15:0] qd);
        add_header(16'($urandom), 16'($urandom), qd, 16'($urandom), 16'($urandom),
                   16'($urandom));
    endtask

    task automatic add_label(input int len);
        msg_bytes.push_back(8'(len));
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_message();
        int mode;
        int labels;
        int cut;
        logic tcp;
        logic [15:0] qd;
        mode = $urandom_range(0, 19);
        tcp  = ($urandom_range(0, 99) < 15);
        qd   = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        if (mode < 15) begin
            add_random_header(qd);
            labels = $urandom_range(1, 4);
            repeat (labels)
                add_label(($urandom_range(0, 4) == 0) ? $urandom_range(9, 63)
                                                      : $urandom_range(1, 8));
            if ($urandom_range(0, 99) < 85) msg_bytes.push_back(dhqp_pkg::NUL_CHAR);
            add_random_bytes($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
            end
        end else if (mode < 17) begin
            add_random_bytes($urandom_range(1, 12));
        end else if (mode < 19) begin
            add_random_bytes($urandom_range(12, 40));
        end else begin
            add_random_header(16'($urandom_range(1, 65535)));
            repeat ($urandom_range(3, 5)) add_label(63);
            add_label($urandom_range(50, 63));
            msg_bytes.push_back(dhqp_pkg::NUL_CHAR);
            tcp = 1'b0;
        end
        send_message(tcp);
    endtask

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int msg_count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // one-byte message, then one cut just short of a full header
        msg_bytes.push_back(8'hFF);
        send_message(1'b0);
        add_random_bytes(11);
        send_message(1'b0);

        // bare headers: empty question, then TCP with a name that must be skipped
        add_header(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_message(1'b0);
        add_header(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        add_label(3);
        msg_bytes.push_back(dhqp_pkg::NUL_CHAR);
        send_message(1'b1);

        // well-formed name with trailing bytes after the terminator
        add_header(16'h1234, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        add_label(3);
        add_label(2);
        msg_bytes.push_back(dhqp_pkg::NUL_CHAR);
        add_word(16'h0001);
        add_word(16'h0001);
        send_message(1'b0);

        // message ends right after a length byte
        add_random_header(16'h0001);
        add_label(2);
        msg_bytes.push_back(8'd3);
        send_message(1'b0);

        // message ends inside a label
        add_random_header(16'h0002);
        add_label(5);
        void'(msg_bytes.pop_back());
        void'(msg_bytes.pop_back());
        send_message(1'b0);

        // two names cut by the length limit: one at its final one-byte label, one at its fourth
        add_random_header(16'h0001);
        add_label(63);
        add_label(63);
        add_label(63);
        add_label(62);
        add_label(1);
        msg_bytes.push_back(dhqp_pkg::NUL_CHAR);
        send_message(1'b0);
        add_random_header(16'h0001);
        repeat (3) add_label(63);
        msg_bytes.push_back(8'd63);
        add_random_bytes(2);
        send_message(1'b0);

        // single label just past the limit
        add_random_header(16'h0001);
        msg_bytes.push_back(8'd255);
        add_random_bytes(3);
        send_message(1'b0);

        wait_drained();

        msg_count = 0;
        while (sent_bytes < 900) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            random_message();
            msg_count++;
            if (msg_count % 8 == 0) wait_drained();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/dhqp_pkg.sv
src/dhqp_parser.sv
src/dhqp_out_fifo.sv
src/dns_header_and_qname_parser_core.sv
bench/dhqp_checker.sv
bench/tb_dns_header_and_qname_parser_core.sv
